/* hw/rtl/fcrw_pkg.sv */
// fcrw_pkg: constants shared by the framed command receiver with link watchdog
// frame delimiters, default timeout, default payload length and input codes
// no dependencies
`default_nettype none

package fcrw_pkg;

  localparam logic [7:0]  START_BYTE        = 8'd255;
  localparam logic [7:0]  END_BYTE          = 8'd240;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd500;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;

  // item kind carried on the func field
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // payload byte positions of the decoded controls
  localparam int unsigned IDX_BUTTONS       = 0;
  localparam int unsigned IDX_THROTTLE      = 3;
  localparam int unsigned IDX_HEADING       = 4;
  localparam int unsigned IDX_LEFT_TRIGGER  = 6;
  localparam int unsigned IDX_RIGHT_TRIGGER = 7;

endpackage

`default_nettype wire

/* hw/rtl/framed_command_receiver_watchdog.sv */
// framed_command_receiver_watchdog: serial command deframer with additive
// checksum, payload latch and a tick-driven link watchdog
// depends on fcrw_pkg
`default_nettype none

// Each input transaction is either one received serial byte (func = 0) or
// one millisecond tick (func = 1), and it yields exactly one result
// transaction. A frame is 0xFF, PayloadBytes payload bytes, a checksum byte
// equal to the payload sum modulo 256, then 0xF0. A good frame latches its
// payload, raises link_up and restarts the idle counter; a bad checksum
// pulses checksum_bad and a missing end byte silently drops the frame. While
// the link is up, ticks count idle time and reaching timeout_ticks drops the
// link with a timeout_fired pulse; the decoded controls read zero whenever
// the link is down. The block takes one transaction per clock cycle when the
// output side does not stall. An accepted transaction waits in the input
// register; the single-pass update of the frame position, checksum and
// watchdog state then loads its result into the result register once that
// register is free, and the result is held there until it is taken. The
// input register can still take one transaction while a finished result waits
// in the result register; the next one is stalled until the result is taken.
// timeout_ticks is written through cfg_we/cfg_data and resets to 500; write
// it only while the block is idle.
module framed_command_receiver_watchdog #(
  parameter int unsigned PayloadBytes = fcrw_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        link_up,
  output logic        frame_ok,
  output logic        checksum_bad,
  output logic        timeout_fired,
  output logic [5:0]  buttons,
  output logic [7:0]  throttle,
  output logic [7:0]  heading,
  output logic [7:0]  left_trigger,
  output logic [7:0]  right_trigger
);
  import fcrw_pkg::*;

  // frame position: 0 hunting, 1..N payload, N+1 checksum, N+2 end byte
  localparam int unsigned PosW = $clog2(PayloadBytes + 3);
  localparam logic [PosW-1:0] PosHunt  = '0;
  localparam logic [PosW-1:0] PosLastP = PosW'(PayloadBytes);
  localparam logic [PosW-1:0] PosChk   = PosW'(PayloadBytes + 1);

  // configuration register
  logic [15:0] timeout_ticks;

  // input register
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_byte;

  // receiver and watchdog state
  logic [PosW-1:0] frame_pos, frame_pos_next;
  logic [7:0]      running_sum, running_sum_next;
  logic            link_flag, link_flag_next;
  logic [15:0]     idle_count, idle_count_next;
  logic [7:0]      payload_buf     [PayloadBytes];
  logic [7:0]      latched_payload [PayloadBytes];

  logic advance;
  logic in_accept;
  logic buf_we;
  logic latch_en;
  logic ok_next, bad_next, fired_next;
  logic [15:0] idle_inc;

  // result register loads when empty or when its transaction is taken
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // saturating idle increment
  assign idle_inc = (idle_count != 16'hFFFF) ? idle_count + 16'd1 : idle_count;

  // byte at a fixed payload position, zero past the end of a short payload
  function automatic logic [7:0] latched_at(input int unsigned idx);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < PayloadBytes; i++) begin
      if (idx == i) r = latched_payload[i];
    end
    return r;
  endfunction

  // single-pass update for the transaction held in the input register
  always_comb begin
    frame_pos_next   = frame_pos;
    running_sum_next = running_sum;
    link_flag_next   = link_flag;
    idle_count_next  = idle_count;
    buf_we           = 1'b0;
    latch_en         = 1'b0;
    ok_next          = 1'b0;
    bad_next         = 1'b0;
    fired_next       = 1'b0;
    if (s1_func == FUNC_BYTE) begin
      if (frame_pos == PosHunt) begin
        // hunting: only the start byte opens a frame
        if (s1_byte == START_BYTE) frame_pos_next = PosW'(1);
      end else if (frame_pos <= PosLastP) begin
        buf_we           = 1'b1;
        running_sum_next = running_sum + s1_byte;
        frame_pos_next   = frame_pos + PosW'(1);
      end else if (frame_pos == PosChk) begin
        // the sum restarts whether or not it matched
        running_sum_next = '0;
        if (s1_byte == running_sum) begin
          frame_pos_next = frame_pos + PosW'(1);
        end else begin
          frame_pos_next = PosHunt;
          bad_next       = 1'b1;
        end
      end else begin
        // end byte slot: a wrong byte drops the frame and is not a new start
        frame_pos_next = PosHunt;
        if (s1_byte == END_BYTE) begin
          latch_en        = 1'b1;
          link_flag_next  = 1'b1;
          idle_count_next = '0;
          ok_next         = 1'b1;
        end
      end
    end else if (link_flag) begin
      // watchdog tick, ignored while the link is down
      idle_count_next = idle_inc;
      if (idle_inc >= timeout_ticks) begin
        link_flag_next  = 1'b0;
        idle_count_next = '0;
        fired_next      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      frame_pos     <= PosHunt;
      running_sum   <= '0;
      link_flag     <= 1'b0;
      idle_count    <= '0;
    end else begin
      if (cfg_we) timeout_ticks <= cfg_data;

      if (in_accept) begin
        s1_valid <= 1'b1;
        s1_func  <= func;
        s1_byte  <= rx_byte;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid   <= 1'b1;
        frame_pos   <= frame_pos_next;
        running_sum <= running_sum_next;
        link_flag   <= link_flag_next;
        idle_count  <= idle_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload capture and latch, no reset needed: every byte is written
  // before a frame can be latched
  always_ff @(posedge clk) begin
    for (int i = 0; i < PayloadBytes; i++) begin
      if (advance && buf_we && frame_pos == PosW'(i + 1)) payload_buf[i] <= s1_byte;
      if (advance && latch_en) latched_payload[i] <= payload_buf[i];
    end
  end

  // result fields; controls come from the new latch contents on a good frame
  logic [7:0] ctl_buttons, ctl_throttle, ctl_heading, ctl_left, ctl_right;

  always_comb begin
    ctl_buttons  = latched_at(IDX_BUTTONS);
    ctl_throttle = latched_at(IDX_THROTTLE);
    ctl_heading  = latched_at(IDX_HEADING);
    ctl_left     = latched_at(IDX_LEFT_TRIGGER);
    ctl_right    = latched_at(IDX_RIGHT_TRIGGER);
    if (latch_en) begin
      for (int i = 0; i < PayloadBytes; i++) begin
        if (IDX_BUTTONS == i)       ctl_buttons  = payload_buf[i];
        if (IDX_THROTTLE == i)      ctl_throttle = payload_buf[i];
        if (IDX_HEADING == i)       ctl_heading  = payload_buf[i];
        if (IDX_LEFT_TRIGGER == i)  ctl_left     = payload_buf[i];
        if (IDX_RIGHT_TRIGGER == i) ctl_right    = payload_buf[i];
      end
    end
    if (!link_flag_next) begin
      ctl_buttons  = '0;
      ctl_throttle = '0;
      ctl_heading  = '0;
      ctl_left     = '0;
      ctl_right    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      link_up       <= link_flag_next;
      frame_ok      <= ok_next;
      checksum_bad  <= bad_next;
      timeout_fired <= fired_next;
      buttons       <= ctl_buttons[5:0];
      throttle      <= ctl_throttle;
      heading       <= ctl_heading;
      left_trigger  <= ctl_left;
      right_trigger <= ctl_right;
    end
  end

  // a completed frame always leaves the link up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> link_up)
    else $error("frame_ok without link_up");

  // a watchdog drop never coincides with a frame event
  assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_fired |-> !link_up && !frame_ok && !checksum_bad)
    else $error("timeout_fired with link up or frame event");

  // controls are forced to zero while the link is down
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !link_up |-> buttons == '0 && throttle == '0 && heading == '0
      && left_trigger == '0 && right_trigger == '0)
    else $error("controls not zero with link down");

  // the input side only stalls when the input register holds a transaction
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
